[rtl/json_string_unescape_utf8_top_macros.svh]
// Assertion macros for the JSON string unescaper.
// Included by json_string_unescape_utf8_top.sv; depends on nothing else.
`ifndef JSON_STRING_UNESCAPE_UTF8_TOP_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define JSU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("jsu assertion failed");

// Next-cycle implication, disabled while reset is held.
`define JSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("jsu assertion failed");

`endif

[rtl/jsu_pkg.sv]
// Shared types and codes of the JSON string unescaper.
// Used by every module in the rtl folder; depends on nothing.
package jsu_pkg;

    localparam logic [1:0] ST_DATA   = 2'd0;
    localparam logic [1:0] ST_CLOSED = 2'd1;
    localparam logic [1:0] ST_BAD    = 2'd2;
    localparam logic [1:0] ST_ENDED  = 2'd3;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_N = 8'h6e;
    localparam logic [7:0] CH_LOWER_R = 8'h72;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_LOWER_U = 8'h75;

    typedef enum logic [5:0] {
        PH_NORMAL  = 6'b000001,
        PH_ESCAPE  = 6'b000010,
        PH_HEX_A   = 6'b000100,
        PH_WANT_BS = 6'b001000,
        PH_WANT_U  = 6'b010000,
        PH_HEX_B   = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       source_ends;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last;
    } t_out;

    // All results caused by one input byte, first byte in bytes[0].
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic [1:0]      status;
    } t_rec;

    typedef struct packed {
        logic valid;
        t_rec rec;
    } t_rec_chan;

endpackage

[rtl/jsu_front.sv]
// Front end: escape and surrogate state machine, one input byte per cycle while i_take is high.
// Depends on jsu_pkg; feeds at most one result record per byte into the record queue.
module jsu_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  jsu_pkg::t_in       i_item,
    output jsu_pkg::t_rec_chan o_rec
);

    jsu_pkg::t_phase r_phase, n_phase;
    logic [1:0]      r_hex, n_hex;
    logic [15:0]     r_acc, n_acc;
    logic [9:0]      r_hs, n_hs;

    logic [7:0]  c;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] acc_new;
    logic [20:0] cp;
    logic [3:0][7:0] enc_bytes;
    logic [1:0]  enc_last;
    logic        emit;
    logic [1:0]  code;
    jsu_pkg::t_rec n_rec;

    assign c       = i_item.data_byte;
    assign acc_new = {r_acc[11:0], hex_val};
    assign cp = (r_phase == jsu_pkg::PH_HEX_B)
              ? 21'h10000 + {1'b0, r_hs, 10'b0} + {11'b0, acc_new[9:0]}
              : {5'b0, acc_new};

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'h0;
        if (c inside {[8'h30:8'h39]}) begin
            hex_val = 4'(c - 8'h30);
        end else if (c inside {[8'h61:8'h66]}) begin
            hex_val = 4'(c - 8'h57);
        end else if (c inside {[8'h41:8'h46]}) begin
            hex_val = 4'(c - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        enc_bytes = '0;
        if (cp <= 21'h7f) begin
            enc_bytes[0] = cp[7:0];
            enc_last     = 2'd0;
        end else if (cp <= 21'h7ff) begin
            enc_bytes[0] = {3'b110, cp[10:6]};
            enc_bytes[1] = {2'b10, cp[5:0]};
            enc_last     = 2'd1;
        end else if (cp <= 21'hffff) begin
            enc_bytes[0] = {4'b1110, cp[15:12]};
            enc_bytes[1] = {2'b10, cp[11:6]};
            enc_bytes[2] = {2'b10, cp[5:0]};
            enc_last     = 2'd2;
        end else begin
            enc_bytes[0] = {5'b11110, cp[20:18]};
            enc_bytes[1] = {2'b10, cp[17:12]};
            enc_bytes[2] = {2'b10, cp[11:6]};
            enc_bytes[3] = {2'b10, cp[5:0]};
            enc_last     = 2'd3;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_hex   = r_hex;
        n_acc   = r_acc;
        n_hs    = r_hs;
        n_rec   = '0;
        emit    = 1'b0;
        code    = jsu_pkg::ST_DATA;

        case (r_phase)
            jsu_pkg::PH_ESCAPE: begin
                n_phase = jsu_pkg::PH_NORMAL;
                emit    = 1'b1;
                case (c)
                    jsu_pkg::CH_LOWER_B: n_rec.bytes[0] = 8'h08;
                    jsu_pkg::CH_LOWER_F: n_rec.bytes[0] = 8'h0c;
                    jsu_pkg::CH_LOWER_N: n_rec.bytes[0] = 8'h0a;
                    jsu_pkg::CH_LOWER_R: n_rec.bytes[0] = 8'h0d;
                    jsu_pkg::CH_LOWER_T: n_rec.bytes[0] = 8'h09;
                    jsu_pkg::CH_LOWER_U: begin
                        emit    = 1'b0;
                        n_phase = jsu_pkg::PH_HEX_A;
                        n_hex   = 2'd0;
                        n_acc   = 16'h0;
                    end
                    default: n_rec.bytes[0] = c;
                endcase
            end
            jsu_pkg::PH_HEX_A, jsu_pkg::PH_HEX_B: begin
                if (!hex_ok) begin
                    code = jsu_pkg::ST_BAD;
                end else begin
                    n_acc = acc_new;
                    if (r_hex != 2'd3) begin
                        n_hex = r_hex + 2'd1;
                    end else begin
                        n_hex = 2'd0;
                        if (r_phase == jsu_pkg::PH_HEX_A) begin
                            if (acc_new inside {[16'hd800:16'hdbff]}) begin
                                n_hs    = acc_new[9:0];
                                n_phase = jsu_pkg::PH_WANT_BS;
                            end else if (acc_new inside {[16'hdc00:16'hdfff]}) begin
                                code = jsu_pkg::ST_BAD;
                            end else begin
                                emit           = 1'b1;
                                n_rec.bytes    = enc_bytes;
                                n_rec.last_idx = enc_last;
                                n_phase        = jsu_pkg::PH_NORMAL;
                            end
                        end else begin
                            if (acc_new inside {[16'hdc00:16'hdfff]}) begin
                                emit           = 1'b1;
                                n_rec.bytes    = enc_bytes;
                                n_rec.last_idx = enc_last;
                                n_phase        = jsu_pkg::PH_NORMAL;
                            end else begin
                                code = jsu_pkg::ST_BAD;
                            end
                        end
                    end
                end
            end
            jsu_pkg::PH_WANT_BS: begin
                if (c == jsu_pkg::CH_BSLASH) begin
                    n_phase = jsu_pkg::PH_WANT_U;
                end else begin
                    code = jsu_pkg::ST_BAD;
                end
            end
            jsu_pkg::PH_WANT_U: begin
                if (c == jsu_pkg::CH_LOWER_U) begin
                    n_phase = jsu_pkg::PH_HEX_B;
                    n_hex   = 2'd0;
                    n_acc   = 16'h0;
                end else begin
                    code = jsu_pkg::ST_BAD;
                end
            end
            default: begin
                n_phase = jsu_pkg::PH_NORMAL;
                if (c == jsu_pkg::CH_QUOTE) begin
                    code = jsu_pkg::ST_CLOSED;
                end else if (c == jsu_pkg::CH_BSLASH) begin
                    n_phase = jsu_pkg::PH_ESCAPE;
                end else begin
                    emit           = 1'b1;
                    n_rec.bytes[0] = c;
                end
            end
        endcase

        // A terminal code or the end of the source replaces any data with a
        // single status result and returns every state register to reset.
        if (code != jsu_pkg::ST_DATA || i_item.source_ends) begin
            emit         = 1'b1;
            n_rec        = '0;
            n_rec.status = (code != jsu_pkg::ST_DATA) ? code : jsu_pkg::ST_ENDED;
            n_phase      = jsu_pkg::PH_NORMAL;
            n_hex        = 2'd0;
            n_acc        = 16'h0;
            n_hs         = 10'h0;
        end
    end

    assign o_rec.valid = i_take && emit;
    assign o_rec.rec   = n_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= jsu_pkg::PH_NORMAL;
            r_hex   <= 2'd0;
            r_acc   <= 16'h0;
            r_hs    <= 10'h0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_hex   <= n_hex;
            r_acc   <= n_acc;
            r_hs    <= n_hs;
        end
    end

endmodule

[rtl/jsu_fifo.sv]
// Short queue of result records between the front end and the back end.
// Depends on jsu_pkg; the head record is shown while the queue is not empty.
module jsu_fifo #(
    parameter int DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jsu_pkg::t_rec_chan i_wr,
    input  logic               i_rd,
    output jsu_pkg::t_rec_chan o_head,
    output logic               o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    jsu_pkg::t_rec r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_wr, do_rd;

    assign do_rd = i_rd && (r_cnt != '0);
    assign do_wr = i_wr.valid && (r_cnt != FULL_CNT);

    assign o_head.valid = (r_cnt != '0);
    assign o_head.rec   = r_mem[r_rp];
    assign o_full       = (r_cnt == FULL_CNT);

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_wr.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + AW'(1);
            end
            if (do_rd) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + AW'(1);
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

[rtl/jsu_back.sv]
// Back end: holds one record and hands out its results one request at a time.
// Depends on jsu_pkg; draws records from the record queue.
module jsu_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jsu_pkg::t_rec_chan i_head,
    output logic               o_head_rd,
    output logic               o_empty,
    input  logic               i_pop,
    output jsu_pkg::t_out      o_out
);

    logic          r_valid;
    jsu_pkg::t_rec r_rec;
    logic [1:0]    r_idx;
    logic          at_last;
    logic          taken;
    logic          load;

    assign at_last = (r_idx == r_rec.last_idx);
    assign taken   = r_valid && i_pop;
    // A new record is loaded when the register is free or its final result
    // leaves in this cycle, so single-result records stream at full rate.
    assign load      = i_head.valid && (!r_valid || (taken && at_last));
    assign o_head_rd = load;

    assign o_empty        = !r_valid;
    assign o_out.out_byte = r_rec.bytes[r_idx];
    assign o_out.status   = r_rec.status;
    assign o_out.last     = at_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec <= i_head.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (taken) begin
            if (at_last) begin
                r_valid <= 1'b0;
                r_idx   <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

endmodule

[rtl/json_string_unescape_utf8_top.sv]
// Top level of the JSON string unescaper: front end, record queue, back end.
// Depends on jsu_pkg, jsu_front, jsu_fifo, jsu_back and the macros header.
//
//   Channel   Direction  Handshake          Payload
//   input     in         push / full        i_in_item  (jsu_pkg::t_in)
//   result    out        empty / pop        o_out_item (jsu_pkg::t_out)
//
// The front end takes one byte per cycle while the record queue has room.
// Each byte yields zero or one record; while pop is held the back end hands
// out one result per cycle, so a \u escape producing n UTF-8 bytes yields n results.
// The first result of a byte reaches the result ports after it is registered
// in the record queue and then in the back-end record register.
// Reset is synchronous and active low; it empties the queue and clears the
// decoder state. Either side may stall without losing results.
`include "json_string_unescape_utf8_top_macros.svh"

module json_string_unescape_utf8_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  jsu_pkg::t_in  i_in_item,
    output logic          empty,
    input  logic          pop,
    output jsu_pkg::t_out o_out_item
);

    jsu_pkg::t_rec_chan f2q;
    jsu_pkg::t_rec_chan q2b;
    logic               q_full;
    logic               q_rd;
    logic               take;
    logic               status_shown;
    logic               last_leaves;

    assign full = q_full;
    assign take = push && !q_full;

    jsu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (i_in_item),
        .o_rec   (f2q)
    );

    jsu_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f2q),
        .i_rd    (q_rd),
        .o_head  (q2b),
        .o_full  (q_full)
    );

    jsu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (q2b),
        .o_head_rd (q_rd),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_out     (o_out_item)
    );

    assign status_shown = !empty && (o_out_item.status != jsu_pkg::ST_DATA);
    assign last_leaves  = pop && !empty && o_out_item.last && q2b.valid;

    // Status results never carry a data byte and always close their request.
    `JSU_ASSERT_NOW(a_status_zero_byte, i_clk, i_rst_n, status_shown, o_out_item.out_byte == 8'h00)
    `JSU_ASSERT_NOW(a_status_is_last, i_clk, i_rst_n, status_shown, o_out_item.last)
    // A queued record must follow a finished one without a gap.
    `JSU_ASSERT_NEXT(a_no_gap, i_clk, i_rst_n, last_leaves, !empty)

endmodule
